FILE: rtl/smeu_pkg.sv
package smeu_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_COUNT = 64;
    localparam int PC_WIDTH    = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int LA_W        = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    localparam logic [4:0] OP_DUP    = 5'd0;
    localparam logic [4:0] OP_POP    = 5'd1;
    localparam logic [4:0] OP_ADD    = 5'd2;
    localparam logic [4:0] OP_SUB    = 5'd3;
    localparam logic [4:0] OP_MUL    = 5'd4;
    localparam logic [4:0] OP_DIV    = 5'd5;
    localparam logic [4:0] OP_POW    = 5'd6;
    localparam logic [4:0] OP_CJUMP  = 5'd7;
    localparam logic [4:0] OP_LOAD   = 5'd8;
    localparam logic [4:0] OP_STORE  = 5'd9;
    localparam logic [4:0] OP_JUMP   = 5'd10;
    localparam logic [4:0] OP_RJUMP  = 5'd11;
    localparam logic [4:0] OP_CRJUMP = 5'd12;
    localparam logic [4:0] OP_EQ     = 5'd13;
    localparam logic [4:0] OP_LT     = 5'd14;
    localparam logic [4:0] OP_AND    = 5'd15;
    localparam logic [4:0] OP_OR     = 5'd16;
    localparam logic [4:0] OP_NOT    = 5'd17;
    localparam logic [4:0] OP_LIT    = 5'd18;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_BADIDX = 3'd4;

    localparam logic [1:0] AL_DIV = 2'd0;
    localparam logic [1:0] AL_POW = 2'd1;

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [31:0] literal_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         depth;
        logic [15:0]        next_pc;
        logic               branch_taken;
        logic [2:0]         status;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_ctl_t;

endpackage

FILE: rtl/smeu_ram.sv
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/smeu_alu.sv
// Iterative divide (restoring, 1 bit/cycle) and power (square-and-multiply).
module smeu_alu
    import smeu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_ctl_t    ctl,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg, busy_next;
    logic [1:0]  op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        phase_reg, phase_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] qfin;
    logic [31:0] prod;
    logic [31:0] mul_a, mul_b;

    always_comb
    begin
        mul_a = phase_reg ? x_reg : acc_reg;
        mul_b = x_reg;
        prod  = mul_a * mul_b;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_sh     = {acc_reg[30:0], x_reg[31]};
        trial      = {1'b0, rem_sh} - {1'b0, y_reg};
        qfin       = 32'd0;
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            op_next    = ctl.op;
            cnt_next   = 6'd0;
            phase_next = 1'b0;
            if (ctl.op == AL_DIV)
            begin
                // opa divisor, opb dividend
                x_next   = opb[31] ? (32'd0 - opb) : opb;
                y_next   = opa[31] ? (32'd0 - opa) : opa;
                neg_next = opa[31] ^ opb[31];
                acc_next = 32'd0;
            end
            else
            begin
                // opa base, opb exponent
                x_next   = opa;
                y_next   = opb;
                acc_next = 32'd1;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == AL_DIV)
            begin
                if (!trial[32])
                begin
                    acc_next = trial[31:0];
                end
                else
                begin
                    acc_next = rem_sh;
                end
                x_next   = {x_reg[30:0], ~trial[32]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    qfin      = {x_reg[30:0], ~trial[32]};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = neg_reg ? (32'd0 - qfin) : qfin;
                end
            end
            else if (y_reg[31])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (x_reg == 32'd1)
                begin
                    res_next = 32'd1;
                end
                else if (x_reg == 32'hFFFF_FFFF)
                begin
                    res_next = y_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                end
                else
                begin
                    res_next = 32'd0;
                end
            end
            else if (y_reg == 32'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = acc_reg;
            end
            else if (!phase_reg)
            begin
                if (y_reg[0])
                begin
                    acc_next = prod;
                end
                phase_next = 1'b1;
            end
            else
            begin
                x_next     = prod;
                y_next     = {1'b0, y_reg[31:1]};
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !ctl.start) else $error("alu restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("alu done while busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("alu done without work");

endmodule

FILE: rtl/stack_machine_execute_unit.sv
// Each item steps through stack reads of the top two entries, one local
// memory read, execute, a finish step (third entry read, write-back) and the
// result; div and pow also wait on the iterative ALU (pow: square-and-multiply,
// two multiplies per exponent bit). One item at a time; next item accepted after the result is taken.
// Reset: sp and pc clear at once; then a clearing pass writes zero to each of the
// LOCAL_COUNT local memory entries before the first item is accepted.
module stack_machine_execute_unit
    import smeu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_ALU  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic [LA_W:0]       clr_reg, clr_next;
    logic [4:0]          kind_reg, kind_next;
    logic [31:0]         lit_reg, lit_next;
    logic [31:0]         a_reg, a_next;
    logic [31:0]         b_reg, b_next;
    logic [31:0]         top_reg, top_next;
    logic [31:0]         res_reg, res_next;
    out_item_t           out_reg, out_next;

    logic [1:0] pops, pushes;
    logic [SP_W+1:0] sp_after;

    logic                s_we;
    logic [SA_W-1:0]     s_waddr, s_raddr;
    logic [31:0]         s_wdata, s_rdata;
    logic                l_we;
    logic [LA_W-1:0]     l_waddr, l_raddr;
    logic [31:0]         l_wdata, l_rdata;

    alu_ctl_t    alu_ctl;
    logic        alu_done;
    logic [31:0] alu_res;

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    smeu_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT > 1 ? LOCAL_COUNT : 2)) u_locals (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    smeu_alu u_alu (
        .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .opa(a_reg), .opb(s_rdata),
        .done(alu_done), .result(alu_res)
    );

    function automatic logic idx_ok(input logic [31:0] v);
        idx_ok = !v[31] && (v < 32'(LOCAL_COUNT));
    endfunction

    always_comb
    begin
        pops   = 2'd0;
        pushes = 2'd0;
        case (kind_reg)
            OP_DUP: begin pops = 2'd1; pushes = 2'd2; end
            OP_POP, OP_JUMP, OP_RJUMP: pops = 2'd1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW,
            OP_EQ, OP_LT, OP_AND, OP_OR: begin pops = 2'd2; pushes = 2'd1; end
            OP_CJUMP, OP_STORE, OP_CRJUMP: pops = 2'd2;
            OP_LOAD, OP_NOT: begin pops = 2'd1; pushes = 2'd1; end
            OP_LIT: pushes = 2'd1;
            default: pops = 2'd0;
        endcase
        sp_after = (SP_W+2)'(sp_reg) - (SP_W+2)'(pops) + (SP_W+2)'(pushes);
    end

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        pc_next    = pc_reg;
        clr_next   = clr_reg;
        kind_next  = kind_reg;
        lit_next   = lit_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        s_we       = 1'b0;
        s_waddr    = SA_W'(sp_reg);
        s_wdata    = res_reg;
        s_raddr    = SA_W'(sp_reg - SP_W'(1));
        l_we       = 1'b0;
        l_waddr    = LA_W'(clr_reg);
        l_wdata    = 32'd0;
        l_raddr    = LA_W'(a_reg);
        alu_ctl    = '0;
        in_ready   = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                l_we     = 1'b1;
                clr_next = clr_reg + (LA_W+1)'(1);
                if (clr_reg == (LA_W+1)'(LOCAL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    lit_next   = in_data.literal_value;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // top entry is here; issue second read
                a_next     = s_rdata;
                s_raddr    = SA_W'(sp_reg - SP_W'(2));
                state_next = S_RD2;
            end
            S_RD2:
            begin
                s_raddr    = SA_W'(sp_reg - SP_W'(2));
                state_next = S_EXE;
            end
            S_EXE:
            begin
                // s_rdata = second entry; a_reg = top; l_rdata = local[a]
                s_raddr  = SA_W'(sp_reg - SP_W'(3));
                out_next.branch_taken = 1'b0;
                out_next.status       = ST_OK;
                pc_next  = pc_reg + PC_WIDTH'(1);
                res_next = 32'd0;
                state_next = S_FIN;
                if (sp_reg < SP_W'(pops))
                begin
                    out_next.status = ST_UNDER;
                    pc_next = pc_reg;
                end
                else if (sp_after > (SP_W+2)'(STACK_DEPTH))
                begin
                    out_next.status = ST_OVER;
                    pc_next = pc_reg;
                end
                else
                begin
                    b_next = s_rdata;
                    case (kind_reg)
                        OP_DUP:  res_next = a_reg;
                        OP_ADD:  res_next = s_rdata + a_reg;
                        OP_SUB:  res_next = s_rdata - a_reg;
                        OP_MUL:  res_next = s_rdata * a_reg;
                        OP_DIV, OP_POW:
                        begin
                            if (kind_reg == OP_DIV && a_reg == 32'd0)
                            begin
                                out_next.status = ST_DIVZ;
                                pc_next = pc_reg;
                            end
                            else
                            begin
                                state_next = S_ALU;
                            end
                        end
                        OP_CJUMP, OP_CRJUMP:
                        begin
                            if (s_rdata != 32'd0)
                            begin
                                out_next.branch_taken = 1'b1;
                                pc_next = (kind_reg == OP_CJUMP) ? PC_WIDTH'(a_reg)
                                        : pc_reg + PC_WIDTH'(a_reg);
                            end
                        end
                        OP_LOAD:
                        begin
                            if (idx_ok(a_reg)) res_next = l_rdata;
                            else
                            begin
                                out_next.status = ST_BADIDX;
                                pc_next = pc_reg;
                            end
                        end
                        OP_STORE:
                        begin
                            if (!idx_ok(s_rdata))
                            begin
                                out_next.status = ST_BADIDX;
                                pc_next = pc_reg;
                            end
                        end
                        OP_JUMP:
                        begin
                            out_next.branch_taken = 1'b1;
                            pc_next = PC_WIDTH'(a_reg);
                        end
                        OP_RJUMP:
                        begin
                            out_next.branch_taken = 1'b1;
                            pc_next = pc_reg + PC_WIDTH'(a_reg);
                        end
                        OP_EQ:  res_next = {31'd0, s_rdata == a_reg};
                        OP_LT:  res_next = {31'd0, $signed(s_rdata) < $signed(a_reg)};
                        OP_AND: res_next = {31'd0, s_rdata != 32'd0 && a_reg != 32'd0};
                        OP_OR:  res_next = {31'd0, s_rdata != 32'd0 || a_reg != 32'd0};
                        OP_NOT: res_next = {31'd0, a_reg == 32'd0};
                        OP_LIT: res_next = lit_reg;
                        default: res_next = 32'd0;
                    endcase
                end
                if (state_next == S_ALU)
                begin
                    alu_ctl.start = 1'b1;
                    alu_ctl.op    = (kind_reg == OP_DIV) ? AL_DIV : AL_POW;
                    b_next        = s_rdata;
                end
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    res_next   = alu_res;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // s_rdata = third entry from the top (when arriving from S_EXE)
                if (out_reg.status == ST_OK)
                begin
                    sp_next = SP_W'(sp_after);
                    if (pushes == 2'd2)
                    begin
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg);
                    end
                    else if (pushes == 2'd1)
                    begin
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg - SP_W'(pops));
                    end
                    if (kind_reg == OP_STORE)
                    begin
                        l_we    = 1'b1;
                        l_waddr = LA_W'(b_reg);
                        l_wdata = a_reg;
                    end
                    if (pushes != 2'd0)
                    begin
                        top_next = res_reg;
                    end
                    else if (pops == 2'd2)
                    begin
                        top_next = s_rdata;
                    end
                    else if (pops == 2'd1)
                    begin
                        top_next = b_reg;
                    end
                end
                out_next.next_pc = 16'(pc_reg);
                out_next.depth   = 7'(out_reg.status == ST_OK ? SP_W'(sp_after) : sp_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            sp_reg    <= '0;
            pc_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            pc_reg    <= pc_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        lit_reg  <= lit_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        out_valid          = (state_reg == S_OUT);
        out_data           = out_reg;
        out_data.top_value = (out_reg.depth == 7'd0) ? 32'sd0 : $signed(top_reg);
    end

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_err_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_reg.status != ST_OK) |-> pc_reg == $past(pc_reg, 1))
        else $error("pc moved on error");
    a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid) else $error("result repeated");

endmodule
